>>> src/rv_pkg.sv
package rv_pkg;

   // field widths
   localparam int PRICE_W   = 24;
   localparam int DIFF_W    = 25;
   localparam int MAG_W     = 24;
   localparam int VOL_W     = 32;
   localparam int CFG_LEN_W = 9;

   // register port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;
   localparam int REG_IDX_W = ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

   // window
   localparam int WINDOW_MAX_DEF = 256;
   localparam int LEN_RESET      = 20;
   localparam int LEN_MIN        = 2;

   // shared multiplier and wide arithmetic
   localparam int LIMB_W    = 32;
   localparam int PROD_W    = 2 * LIMB_W;
   localparam int WIDE_W    = 2 * PROD_W;
   localparam int MUL_STEPS = 5;
   localparam int FRAC_SHIFT = 16;

   // defaults for the root/divide unit at the default window depth
   localparam int LEN_W_DEF = 9;
   localparam int VAR_W_DEF = 2 * MAG_W + 8 + LEN_W_DEF;

endpackage

>>> src/rv_req_if.sv
interface rv_req_if;
   logic                       valid;
   logic                       ready;
   logic [rv_pkg::PRICE_W-1:0] close_price;
   logic                       restart;

   modport source  (output valid, close_price, restart, input ready);
   modport sink    (input valid, close_price, restart, output ready);
   modport monitor (input valid, ready, close_price, restart);
endinterface

>>> src/rv_rsp_if.sv
interface rv_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [rv_pkg::VOL_W-1:0] volatility;
   logic                     ready_res;

   modport source  (output valid, volatility, ready_res, input ready);
   modport sink    (input valid, volatility, ready_res, output ready);
   modport monitor (input valid, ready, volatility, ready_res);
endinterface

>>> src/rv_root_div.sv
// floor(sqrt(radicand << 16)) one bit pair per cycle, then divide by the
// window length two quotient bits per cycle; quotient saturates to 32 bits.
module rv_root_div #(
   parameter int VAR_W = rv_pkg::VAR_W_DEF,
   parameter int LEN_W = rv_pkg::LEN_W_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VAR_W-1:0]         radicand,
   input  logic [LEN_W-1:0]         divisor,
   output logic                     done,
   output logic [rv_pkg::VOL_W-1:0] quotient
);

   localparam int PAIRS     = (VAR_W + rv_pkg::FRAC_SHIFT + 1) / 2;
   localparam int RAD_W     = 2 * PAIRS;
   localparam int REM_W     = PAIRS + 2;
   localparam int DIV_STEPS = (PAIRS + 1) / 2;
   localparam int QW        = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(PAIRS);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_ROOT = 3'b010,
      U_DIV  = 3'b100
   } unit_state_type;

   unit_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PAIRS-1:0]  root_ff, root_in;
   logic [QW-1:0]     num_ff, num_in;
   logic [LEN_W-1:0]  r_ff, r_in;
   logic [LEN_W-1:0]  div_ff, div_in;

   logic [REM_W-1:0]  rem_sh, trial;
   logic              root_ge;
   logic [PAIRS-1:0]  root_next;
   logic [LEN_W:0]    r1, r1m, r2, r2m;
   logic              q1, q2;

   always_comb begin
      rem_sh    = {rem_ff[PAIRS-1:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      root_ge   = (rem_sh >= trial);
      root_next = {root_ff[PAIRS-2:0], root_ge};

      r1  = {r_ff, num_ff[QW-1]};
      q1  = (r1 >= {1'b0, div_ff});
      r1m = q1 ? (r1 - {1'b0, div_ff}) : r1;
      r2  = {r1m[LEN_W-1:0], num_ff[QW-2]};
      q2  = (r2 >= {1'b0, div_ff});
      r2m = q2 ? (r2 - {1'b0, div_ff}) : r2;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      r_in     = r_ff;
      div_in   = div_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               rad_in   = RAD_W'({radicand, {rv_pkg::FRAC_SHIFT{1'b0}}});
               rem_in   = '0;
               root_in  = '0;
               div_in   = divisor;
               cnt_in   = CNT_W'(PAIRS - 1);
               state_in = U_ROOT;
            end
         end
         U_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = root_ge ? (rem_sh - trial) : rem_sh;
            root_in = root_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               num_in   = QW'(root_next);
               r_in     = '0;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            num_in = {num_ff[QW-3:0], q1, q2};
            r_in   = r2m[LEN_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      r_ff    <= r_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = (|num_ff[QW-1:rv_pkg::VOL_W]) ? '1 : num_ff[rv_pkg::VOL_W-1:0];

endmodule

>>> src/rolling_volatility_core.sv
// Rolling volatility: population standard deviation of the last N
// close-to-close price moves, 8 fraction bits.
//   req_bus : one request per closing price (close_price, restart).
//   rsp_bus : exactly one response per request (volatility, ready_res).
//   APB     : register 0 = window_length (N), clamped to [2, WINDOW_MAX];
//             any write empties the window but keeps the reference price.
// Accept to response valid: a restart or the first price goes to S_DONE;
// a not-yet-full window passes S_SQ_NEW, S_SQ_OLD and S_UPDATE; a full
// window adds S_MUL (five partial products on the shared 32x32 multiplier),
// S_DIFF and S_ROOT (bit-serial square root over P = root bit pairs, 41 at
// WINDOW_MAX = 256, then the 2-bit-per-cycle divide).
// One request at a time: the next is taken the cycle after the previous
// result loads the output register.
// The differences live in a WINDOW_MAX deep ring memory (registered read),
// read at the write position, then overwritten with the new difference.
// Reset: window empty, no reference price, N = 20; ring contents are not
// cleared (only entries written since the last clear are ever used).
// A stalled response holds in the output register; one more result may
// finish behind it and waits there until the register frees up.
module rolling_volatility_core #(
   parameter int WINDOW_MAX = rv_pkg::WINDOW_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   rv_req_if.sink                       req_bus,
   rv_rsp_if.source                     rsp_bus,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rv_pkg::ADDR_W-1:0]    paddr,
   input  logic [rv_pkg::DATA_W-1:0]    pwdata,
   output logic [rv_pkg::DATA_W-1:0]    prdata,
   output logic                         pready
);

   localparam int PTR_W   = $clog2(WINDOW_MAX);
   localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
   localparam int DIFF_W  = rv_pkg::DIFF_W;
   localparam int MAG_W   = rv_pkg::MAG_W;
   localparam int SUM_W   = DIFF_W + PTR_W;
   localparam int SQ_W    = 2 * MAG_W + PTR_W;
   localparam int VAR_W   = SQ_W + LEN_W;
   localparam int LIMB_W  = rv_pkg::LIMB_W;
   localparam int PROD_W  = rv_pkg::PROD_W;
   localparam int WIDE_W  = rv_pkg::WIDE_W;
   localparam int LEN_RST = (rv_pkg::LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : rv_pkg::LEN_RESET;
   localparam int MSTEP_W = $clog2(rv_pkg::MUL_STEPS + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SQ_NEW = 8'b0000_0010,
      S_SQ_OLD = 8'b0000_0100,
      S_UPDATE = 8'b0000_1000,
      S_MUL    = 8'b0001_0000,
      S_DIFF   = 8'b0010_0000,
      S_ROOT   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } eng_state_type;

   // control state
   eng_state_type               state_ff, state_in;
   logic [rv_pkg::PRICE_W-1:0]  prev_ff, prev_in;
   logic                        have_prev_ff, have_prev_in;
   logic [PTR_W-1:0]            wr_pos_ff, wr_pos_in;
   logic [LEN_W-1:0]            fill_ff, fill_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [MSTEP_W-1:0]          mstep_ff, mstep_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working payload
   logic [DIFF_W-1:0]           diff_ff, diff_in;
   logic [MAG_W-1:0]            mag_ff, mag_in;
   logic                        evict_ff, evict_in;
   logic [2*MAG_W-1:0]          newsq_ff, newsq_in;
   logic [PROD_W-1:0]           mul_prod_ff;
   logic [VAR_W-1:0]            acc_a_ff, acc_a_in;
   logic [VAR_W-1:0]            acc_b_ff, acc_b_in;
   logic [rv_pkg::VOL_W-1:0]    res_vol_ff, res_vol_in;
   logic                        res_rdy_ff, res_rdy_in;
   logic [rv_pkg::VOL_W-1:0]    rsp_vol_ff, rsp_vol_in;
   logic                        rsp_rdy_ff, rsp_rdy_in;

   // ring memory
   logic [DIFF_W-1:0]           ring_mem [WINDOW_MAX];
   logic [DIFF_W-1:0]           rd_data_ff;
   logic                        mem_re, mem_we;

   // misc combinational
   logic                        req_fire, cfg_we, out_load, root_start, root_done;
   logic [rv_pkg::REG_IDX_W-1:0] reg_idx;
   logic [rv_pkg::CFG_LEN_W-1:0] cfg_len;
   logic [LEN_W-1:0]            len_clamped;
   logic [DIFF_W-1:0]           new_diff, old_abs;
   logic [SUM_W-1:0]            sum_abs;
   logic [PROD_W-1:0]           sq64, m64;
   logic [LIMB_W-1:0]           mul_a, mul_b;
   logic [WIDE_W-1:0]           wide_p;
   logic [LEN_W:0]              pos_inc;
   logic [VAR_W-1:0]            radicand;
   logic [rv_pkg::VOL_W-1:0]    root_q;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign reg_idx  = paddr[rv_pkg::ADDR_W-1:2];
   assign cfg_we   = psel && penable && pwrite && (reg_idx == rv_pkg::REG_WINDOW_LENGTH);
   assign cfg_len  = pwdata[rv_pkg::CFG_LEN_W-1:0];
   assign pready   = 1'b1;
   assign prdata   = (reg_idx == rv_pkg::REG_WINDOW_LENGTH) ? rv_pkg::DATA_W'(len_ff) : '0;

   always_comb begin
      if (32'(cfg_len) < 32'(rv_pkg::LEN_MIN)) begin
         len_clamped = LEN_W'(rv_pkg::LEN_MIN);
      end else if (32'(cfg_len) > 32'(WINDOW_MAX)) begin
         len_clamped = LEN_W'(WINDOW_MAX);
      end else begin
         len_clamped = LEN_W'(cfg_len);
      end
   end

   // magnitudes and wide views
   assign new_diff = {1'b0, req_bus.close_price} - {1'b0, prev_ff};
   assign old_abs  = rd_data_ff[DIFF_W-1] ? (~rd_data_ff + 1'b1) : rd_data_ff;
   assign sum_abs  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign sq64     = PROD_W'(sq_ff);
   assign m64      = PROD_W'(sum_abs);
   assign pos_inc  = {1'b0, LEN_W'(wr_pos_ff)} + 1'b1;

   // shared multiplier operand select: squares, then N*sumsq and sum^2 by limbs
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ_NEW: begin
            mul_a = LIMB_W'(mag_ff);
            mul_b = LIMB_W'(mag_ff);
         end
         S_SQ_OLD: begin
            mul_a = LIMB_W'(old_abs[MAG_W-1:0]);
            mul_b = LIMB_W'(old_abs[MAG_W-1:0]);
         end
         S_MUL: begin
            case (mstep_ff)
               MSTEP_W'(0): begin
                  mul_a = LIMB_W'(len_ff);
                  mul_b = sq64[LIMB_W-1:0];
               end
               MSTEP_W'(1): begin
                  mul_a = LIMB_W'(len_ff);
                  mul_b = sq64[PROD_W-1:LIMB_W];
               end
               MSTEP_W'(2): begin
                  mul_a = m64[LIMB_W-1:0];
                  mul_b = m64[LIMB_W-1:0];
               end
               MSTEP_W'(3): begin
                  mul_a = m64[LIMB_W-1:0];
                  mul_b = m64[PROD_W-1:LIMB_W];
               end
               MSTEP_W'(4): begin
                  mul_a = m64[PROD_W-1:LIMB_W];
                  mul_b = m64[PROD_W-1:LIMB_W];
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // place the previous product at its limb weight (cross term counted twice)
   always_comb begin
      case (mstep_ff)
         MSTEP_W'(2): wide_p = WIDE_W'(mul_prod_ff) << LIMB_W;
         MSTEP_W'(4): wide_p = WIDE_W'(mul_prod_ff) << (LIMB_W + 1);
         MSTEP_W'(5): wide_p = WIDE_W'(mul_prod_ff) << PROD_W;
         default:     wide_p = WIDE_W'(mul_prod_ff);
      endcase
   end

   assign radicand = (acc_a_ff >= acc_b_ff) ? (acc_a_ff - acc_b_ff) : '0;
   assign root_start = (state_ff == S_DIFF);
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign mem_re     = req_fire;
   assign mem_we     = (state_ff == S_SQ_NEW);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      wr_pos_in    = wr_pos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      mstep_in     = mstep_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      evict_in     = evict_ff;
      newsq_in     = newsq_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      res_vol_in   = res_vol_ff;
      res_rdy_in   = res_rdy_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_rdy_in   = rsp_rdy_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               prev_in = req_bus.close_price;
               if (req_bus.restart || !have_prev_ff) begin
                  // new reference price, empty result
                  if (req_bus.restart) begin
                     wr_pos_in = '0;
                     fill_in   = '0;
                     sum_in    = '0;
                     sq_in     = '0;
                  end
                  have_prev_in = 1'b1;
                  res_vol_in   = '0;
                  res_rdy_in   = 1'b0;
                  state_in     = S_DONE;
               end else begin
                  diff_in  = new_diff;
                  mag_in   = new_diff[DIFF_W-1] ? MAG_W'(~new_diff + 1'b1)
                                                : new_diff[MAG_W-1:0];
                  evict_in = (fill_ff >= len_ff);
                  state_in = S_SQ_NEW;
               end
            end
         end
         S_SQ_NEW: begin
            // ring entry is overwritten here; the old one was read at accept
            state_in = S_SQ_OLD;
         end
         S_SQ_OLD: begin
            newsq_in = mul_prod_ff[2*MAG_W-1:0];
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            sum_in = sum_ff + {{PTR_W{diff_ff[DIFF_W-1]}}, diff_ff}
                   - (evict_ff ? {{PTR_W{rd_data_ff[DIFF_W-1]}}, rd_data_ff} : '0);
            sq_in  = sq_ff + SQ_W'(newsq_ff)
                   - (evict_ff ? SQ_W'(mul_prod_ff) : '0);
            wr_pos_in = (pos_inc >= {1'b0, len_ff}) ? '0 : pos_inc[PTR_W-1:0];
            if (fill_ff < len_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            if (((fill_ff < len_ff) ? (fill_ff + 1'b1) : fill_ff) == len_ff) begin
               mstep_in = '0;
               acc_a_in = '0;
               acc_b_in = '0;
               state_in = S_MUL;
            end else begin
               res_vol_in = '0;
               res_rdy_in = 1'b0;
               state_in   = S_DONE;
            end
         end
         S_MUL: begin
            mstep_in = mstep_ff + 1'b1;
            case (mstep_ff)
               MSTEP_W'(1), MSTEP_W'(2): acc_a_in = acc_a_ff + wide_p[VAR_W-1:0];
               MSTEP_W'(3), MSTEP_W'(4), MSTEP_W'(5): acc_b_in = acc_b_ff + wide_p[VAR_W-1:0];
               default: begin
                  acc_a_in = acc_a_ff;
               end
            endcase
            if (mstep_ff == MSTEP_W'(rv_pkg::MUL_STEPS)) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               res_vol_in = root_q;
               res_rdy_in = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_vol_in   = res_vol_ff;
               rsp_rdy_in   = res_rdy_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // length write: empty the window, keep the reference price
      if (cfg_we) begin
         len_in    = len_clamped;
         wr_pos_in = '0;
         fill_in   = '0;
         sum_in    = '0;
         sq_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         wr_pos_ff    <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         len_ff       <= LEN_W'(LEN_RST);
         mstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         len_ff       <= len_in;
         mstep_ff     <= mstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      evict_ff    <= evict_in;
      newsq_ff    <= newsq_in;
      mul_prod_ff <= mul_a * mul_b;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      res_vol_ff  <= res_vol_in;
      res_rdy_ff  <= res_rdy_in;
      rsp_vol_ff  <= rsp_vol_in;
      rsp_rdy_ff  <= rsp_rdy_in;
   end

   // difference ring: read at accept, written in S_SQ_NEW
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_pos_ff] <= diff_ff;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[wr_pos_ff];
      end
   end

   rv_root_div #(
      .VAR_W (VAR_W),
      .LEN_W (LEN_W)
   ) u_root_div (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .divisor  (len_ff),
      .done     (root_done),
      .quotient (root_q)
   );

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.volatility = rsp_vol_ff;
   assign rsp_bus.ready_res  = rsp_rdy_ff;

endmodule

>>> src/rv_checker.sv
module rv_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [rv_pkg::VOL_W-1:0] rsp_volatility,
   input  logic                     rsp_ready_res
);

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_volatility) && $stable(rsp_ready_res))
      else $error("response changed while stalled");

   // no volatility reported before the window is full
   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> rsp_volatility == '0)
      else $error("nonzero volatility with ready_res low");

   // one request at a time: the engine is busy right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in work");

   // reset leaves an idle engine and an empty output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind rolling_volatility_core rv_checker u_rv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_volatility (rsp_bus.volatility),
   .rsp_ready_res  (rsp_bus.ready_res)
);
